// ===== rtl/core/selt_pkg.sv =====
// package: item types, event codes, controller states and command/status structs
package selt_pkg;

    localparam logic [1:0] OP_ACQUIRE = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;
    localparam logic [1:0] OP_NOP     = 2'd3;

    localparam logic [2:0] EV_GRANTED      = 3'd0;
    localparam logic [2:0] EV_GRANTED_WAIT = 3'd1;
    localparam logic [2:0] EV_WAITING      = 3'd2;
    localparam logic [2:0] EV_DEADLOCK     = 3'd3;
    localparam logic [2:0] EV_TIMEOUT      = 3'd4;
    localparam logic [2:0] EV_INVALID      = 3'd5;
    localparam logic [2:0] EV_RELEASED     = 3'd6;

    localparam logic [15:0] TIMEOUT_RESET = 16'd5000;

    typedef struct packed {
        logic [1:0] operation;
        logic [3:0] txn;
        logic [5:0] resource;
        logic       mode;
    } t_in_item;

    typedef struct packed {
        logic [2:0] event_res;
        logic [3:0] event_txn;
        logic [5:0] event_resource;
        logic       last;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DISPATCH,
        ST_HEAD,
        ST_ACQ_CHK,
        ST_BFS_EVAL,
        ST_BFS_NEXT,
        ST_BFS_WAIT,
        ST_REL_RD,
        ST_REL_CLR,
        ST_REL_GCHK,
        ST_REL_NEXT,
        ST_TICK_SCAN,
        ST_TICK_CHK,
        ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        TS_ITEM,
        TS_BEST,
        TS_SCAN
    } t_txn_sel;

    typedef enum logic [1:0] {
        RS_ITEM,
        RS_ZERO,
        RS_CUR
    } t_res_sel;

    typedef struct packed {
        logic       in_ready;
        logic       row_zero;
        logic       res_inc;
        logic       res_zero;
        logic       res_scan;
        logic       head_start;
        logic       head_step;
        logic       enqueue;
        logic       bfs_init;
        logic       bfs_eval;
        logic       bfs_expand;
        logic       row_clear;
        logic       row_grant;
        logic       pend_clr;
        t_txn_sel   tsel;
        logic       emit;
        logic [2:0] ev_code;
        t_res_sel   ev_rsel;
        logic       age_inc;
        logic       w_one;
        logic       w_inc;
        logic       flush;
    } t_cmd;

    typedef struct packed {
        logic       in_valid;
        logic [1:0] op;
        logic       bad;
        logic       t_pend;
        logic       sc_last;
        logic       w_last;
        logic       res_last;
        logic       holds;
        logic       compat;
        logic       best_zero;
        logic       best_eq_w;
        logic       waiter_on_cur;
        logic       w_due;
        logic       reached_start;
        logic       next_found;
        logic       emit_ok;
        logic       hold_v;
        logic       out_free;
    } t_sts;

endpackage

// ===== rtl/core/selt_if.sv =====
// item channel interfaces for requests and events
interface selt_in_if;
    logic                valid;
    logic                ready;
    selt_pkg::t_in_item  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface selt_out_if;
    logic                valid;
    logic                ready;
    selt_pkg::t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/shared_exclusive_lock_table_core.sv =====
// top level of the shared/exclusive lock table
//
//  channel  | dir | handshake    | carries
//  i_in     | in  | valid/ready  | operation, txn, resource, mode
//  o_out    | out | valid/ready  | event_res, event_txn, event_resource, last
//  i_cfg    | in  | write enable | timeout_ticks
//
// one item at a time; acquire runs the serial queue-head scan over the txns and, when it
// queues, walks the wait-for search one txn at a time; invalid and unknown items end at dispatch
// release sweeps the resource rows in turn, with a queue-head scan for each resource with
// waiters and again after each grant
// tick scans the waiter lanes in turn, with a queue-head scan per expired waiter; after
// reset the lock memory is cleared row by row; a full output register stalls the controller
module shared_exclusive_lock_table_core #(
    parameter int NUM_TXNS      = 16,
    parameter int NUM_RESOURCES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    selt_in_if.sink     i_in,
    selt_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);
    import selt_pkg::*;

    t_cmd cmd;
    t_sts sts;

    selt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    selt_dpath #(
        .NUM_TXNS      (NUM_TXNS),
        .NUM_RESOURCES (NUM_RESOURCES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

// ===== rtl/core/selt_ctrl.sv =====
// controller state machine sequencing acquire, release and tick items
module selt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  selt_pkg::t_sts i_sts,
    output selt_pkg::t_cmd o_cmd
);
    import selt_pkg::*;

    t_state r_state, n_state;
    t_state r_ret, n_ret;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_ret   <= ST_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        o_cmd   = '0;
        case (r_state)
            ST_INIT: begin
                o_cmd.row_zero = 1'b1;
                o_cmd.res_inc  = 1'b1;
                if (i_sts.res_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                o_cmd.tsel = TS_ITEM;
                case (i_sts.op)
                    OP_ACQUIRE: begin
                        if (i_sts.bad || i_sts.t_pend) begin
                            o_cmd.emit    = 1'b1;
                            o_cmd.ev_code = EV_INVALID;
                            o_cmd.ev_rsel = RS_ITEM;
                            n_state       = ST_FINISH;
                        end else begin
                            o_cmd.head_start = 1'b1;
                            n_ret            = ST_ACQ_CHK;
                            n_state          = ST_HEAD;
                        end
                    end
                    OP_RELEASE: begin
                        o_cmd.emit    = 1'b1;
                        o_cmd.ev_rsel = RS_ZERO;
                        if (i_sts.bad) begin
                            o_cmd.ev_code = EV_INVALID;
                            n_state       = ST_FINISH;
                        end else begin
                            o_cmd.ev_code  = EV_RELEASED;
                            o_cmd.pend_clr = 1'b1;
                            o_cmd.res_zero = 1'b1;
                            n_state        = ST_REL_RD;
                        end
                    end
                    OP_TICK: begin
                        o_cmd.age_inc = 1'b1;
                        o_cmd.w_one   = 1'b1;
                        n_state       = ST_TICK_SCAN;
                    end
                    default: begin
                        n_state = ST_FINISH;
                    end
                endcase
            end
            ST_HEAD: begin
                o_cmd.head_step = 1'b1;
                if (i_sts.sc_last) begin
                    n_state = r_ret;
                end
            end
            ST_ACQ_CHK: begin
                o_cmd.tsel    = TS_ITEM;
                o_cmd.ev_rsel = RS_ITEM;
                if (i_sts.holds || (i_sts.best_zero && i_sts.compat)) begin
                    o_cmd.row_grant = 1'b1;
                    o_cmd.emit      = 1'b1;
                    o_cmd.ev_code   = EV_GRANTED;
                    n_state         = ST_FINISH;
                end else begin
                    o_cmd.enqueue  = 1'b1;
                    o_cmd.bfs_init = 1'b1;
                    n_state        = ST_BFS_EVAL;
                end
            end
            ST_BFS_EVAL: begin
                o_cmd.bfs_eval = 1'b1;
                n_state        = ST_BFS_NEXT;
            end
            ST_BFS_NEXT: begin
                o_cmd.tsel    = TS_ITEM;
                o_cmd.ev_rsel = RS_ITEM;
                if (i_sts.reached_start) begin
                    o_cmd.pend_clr = 1'b1;
                    o_cmd.emit     = 1'b1;
                    o_cmd.ev_code  = EV_DEADLOCK;
                    n_state        = ST_FINISH;
                end else if (!i_sts.next_found) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.ev_code = EV_WAITING;
                    n_state       = ST_FINISH;
                end else begin
                    o_cmd.bfs_expand = 1'b1;
                    n_state          = ST_BFS_WAIT;
                end
            end
            ST_BFS_WAIT: begin
                n_state = ST_BFS_EVAL;
            end
            ST_REL_RD: begin
                n_state = ST_REL_CLR;
            end
            ST_REL_CLR: begin
                o_cmd.row_clear = 1'b1;
                if (i_sts.waiter_on_cur) begin
                    o_cmd.head_start = 1'b1;
                    n_ret            = ST_REL_GCHK;
                    n_state          = ST_HEAD;
                end else begin
                    n_state = ST_REL_NEXT;
                end
            end
            ST_REL_GCHK: begin
                o_cmd.tsel    = TS_BEST;
                o_cmd.ev_rsel = RS_CUR;
                if (i_sts.best_zero || (!i_sts.holds && !i_sts.compat)) begin
                    n_state = ST_REL_NEXT;
                end else if (i_sts.emit_ok) begin
                    o_cmd.row_grant  = 1'b1;
                    o_cmd.pend_clr   = 1'b1;
                    o_cmd.emit       = 1'b1;
                    o_cmd.ev_code    = EV_GRANTED_WAIT;
                    o_cmd.head_start = 1'b1;
                    n_ret            = ST_REL_GCHK;
                    n_state          = ST_HEAD;
                end
            end
            ST_REL_NEXT: begin
                if (i_sts.res_last) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.res_inc = 1'b1;
                    n_state       = ST_REL_RD;
                end
            end
            ST_TICK_SCAN: begin
                if (i_sts.w_due) begin
                    o_cmd.res_scan   = 1'b1;
                    o_cmd.head_start = 1'b1;
                    n_ret            = ST_TICK_CHK;
                    n_state          = ST_HEAD;
                end else if (i_sts.w_last) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.w_inc = 1'b1;
                end
            end
            ST_TICK_CHK: begin
                o_cmd.tsel    = TS_SCAN;
                o_cmd.ev_rsel = RS_CUR;
                if (i_sts.emit_ok) begin
                    o_cmd.pend_clr = 1'b1;
                    o_cmd.emit     = 1'b1;
                    if (i_sts.holds || (i_sts.best_eq_w && i_sts.compat)) begin
                        o_cmd.row_grant = 1'b1;
                        o_cmd.ev_code   = EV_GRANTED_WAIT;
                    end else begin
                        o_cmd.ev_code = EV_TIMEOUT;
                    end
                    if (i_sts.w_last) begin
                        n_state = ST_FINISH;
                    end else begin
                        o_cmd.w_inc = 1'b1;
                        n_state     = ST_TICK_SCAN;
                    end
                end
            end
            ST_FINISH: begin
                if (!i_sts.hold_v) begin
                    n_state = ST_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/selt_dpath.sv =====
// datapath: lock row memory, waiter lanes, search registers and event registers
module selt_dpath #(
    parameter int NUM_TXNS      = 16,
    parameter int NUM_RESOURCES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    selt_in_if.sink           i_in,
    selt_out_if.source        o_out,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_wdata,
    input  selt_pkg::t_cmd    i_cmd,
    output selt_pkg::t_sts    o_sts
);
    import selt_pkg::*;

    localparam int TW   = $clog2(NUM_TXNS);
    localparam int RW   = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
    localparam int ROWW = TW + NUM_TXNS;
    localparam logic [TW-1:0] T_LAST = TW'(NUM_TXNS - 1);
    localparam logic [RW-1:0] R_LAST = RW'(NUM_RESOURCES - 1);

    function automatic logic [NUM_TXNS-1:0] onehot(input logic [TW-1:0] i);
        logic [NUM_TXNS-1:0] v;
        v    = '0;
        v[i] = 1'b1;
        return v;
    endfunction

    // resource reduction table
    logic [RW-1:0] mod_tab [64];
    for (genvar g = 0; g < 64; g++) begin : g_mod
        assign mod_tab[g] = RW'(g % NUM_RESOURCES);
    end

    logic [1:0]          r_op;
    logic [3:0]          r_txn;
    logic [TW-1:0]       r_tx;
    logic                r_bad;
    logic [RW-1:0]       r_ires;
    logic                r_m;

    logic [NUM_TXNS-1:0] r_pend;
    logic [RW-1:0]       r_pres  [NUM_TXNS];
    logic [NUM_TXNS-1:0] r_pmode;
    logic [31:0]         r_stamp [NUM_TXNS];
    logic [15:0]         r_age   [NUM_TXNS];
    logic [31:0]         r_cnt;
    logic [15:0]         r_tmo;

    logic [RW-1:0]       r_cur;
    logic [ROWW-1:0]     r_rdata;
    logic [ROWW-1:0]     mem [NUM_RESOURCES];
    logic [TW-1:0]       r_sc, r_w, r_best, r_x;
    logic [NUM_TXNS-1:0] r_reached, r_expanded;

    logic                r_out_v;
    t_out_item           r_out;
    logic                r_hold_v;
    t_out_item           r_hold;

    logic                load;
    logic                bad_in;
    logic [31:0]         age32 [NUM_TXNS];
    logic [TW-1:0]       excl;
    logic [NUM_TXNS-1:0] sh;
    logic [TW-1:0]       c_t;
    logic                c_m;
    logic [NUM_TXNS-1:0] c_oh;
    logic                holds, compat;
    logic [ROWW-1:0]     row_g, row_c, row_w;
    logic                row_we;
    logic [NUM_TXNS-1:0] blk;
    logic [NUM_TXNS-1:0] on_cur;
    logic [NUM_TXNS-1:0] cand;
    logic [TW-1:0]       next_idx;
    logic                next_found;
    logic                head_take;
    logic                out_free;
    logic                out_load;
    t_out_item           out_nx;
    t_out_item           ev;

    assign load   = i_in.valid && i_in.ready;
    assign bad_in = (i_in.payload.txn == 4'd0) || (int'(i_in.payload.txn) >= NUM_TXNS);
    assign i_in.ready = i_cmd.in_ready;

    assign excl = r_rdata[ROWW-1 -: TW];
    assign sh   = r_rdata[NUM_TXNS-1:0];

    always_comb begin
        case (i_cmd.tsel)
            TS_BEST: begin
                c_t = r_best;
                c_m = r_pmode[r_best];
            end
            TS_SCAN: begin
                c_t = r_w;
                c_m = r_pmode[r_w];
            end
            default: begin
                c_t = r_tx;
                c_m = r_m;
            end
        endcase
    end

    assign c_oh   = onehot(c_t);
    assign holds  = (excl == c_t) || (!c_m && sh[c_t]);
    assign compat = ((excl == '0) || (excl == c_t)) && (!c_m || ((sh & ~c_oh) == '0));

    always_comb begin
        if (c_m) begin
            row_g = {c_t, sh & ~c_oh};
        end else if (excl != c_t) begin
            row_g = {excl, sh | c_oh};
        end else begin
            row_g = r_rdata;
        end
    end

    assign row_c  = {(excl == r_tx) ? {TW{1'b0}} : excl, sh & ~onehot(r_tx)};
    assign row_we = i_cmd.row_zero || i_cmd.row_clear || i_cmd.row_grant;

    always_comb begin
        if (i_cmd.row_zero) begin
            row_w = '0;
        end else if (i_cmd.row_clear) begin
            row_w = row_c;
        end else begin
            row_w = row_g;
        end
    end

    always_comb begin
        for (int w = 0; w < NUM_TXNS; w++) begin
            age32[w]  = r_cnt - r_stamp[w];
            on_cur[w] = r_pend[w] && (r_pres[w] == r_cur);
        end
    end

    // wait-for edges out of r_x
    always_comb begin
        blk = '0;
        if ((excl != '0) && (excl != r_x)) begin
            blk = blk | onehot(excl);
        end
        if (r_pmode[r_x]) begin
            blk = blk | (sh & ~onehot(r_x));
        end
        for (int w = 0; w < NUM_TXNS; w++) begin
            if ((TW'(w) != r_x) && on_cur[w] && (age32[w] > age32[r_x])) begin
                blk[w] = 1'b1;
            end
        end
    end

    assign cand = r_reached & ~r_expanded & r_pend;

    always_comb begin
        next_idx   = '0;
        next_found = 1'b0;
        for (int w = NUM_TXNS - 1; w >= 1; w--) begin
            if (cand[w]) begin
                next_idx   = TW'(w);
                next_found = 1'b1;
            end
        end
    end

    assign head_take = on_cur[r_sc] && ((r_best == '0) || (age32[r_sc] > age32[r_best]));

    assign out_free = !r_out_v || o_out.ready;

    always_comb begin
        ev.event_res = i_cmd.ev_code;
        ev.last      = 1'b0;
        case (i_cmd.tsel)
            TS_BEST: ev.event_txn = 4'(r_best);
            TS_SCAN: ev.event_txn = 4'(r_w);
            default: ev.event_txn = r_txn;
        endcase
        case (i_cmd.ev_rsel)
            RS_ZERO: ev.event_resource = 6'd0;
            RS_CUR:  ev.event_resource = 6'(r_cur);
            default: ev.event_resource = 6'(r_ires);
        endcase
    end

    // item registers
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_op   <= i_in.payload.operation;
            r_txn  <= i_in.payload.txn;
            r_tx   <= TW'(i_in.payload.txn);
            r_bad  <= bad_in;
            r_ires <= mod_tab[i_in.payload.resource];
            r_m    <= i_in.payload.mode;
        end
    end

    // lock rows
    always_ff @(posedge i_clk) begin
        if (row_we) begin
            mem[r_cur] <= row_w;
            r_rdata    <= row_w;
        end else begin
            r_rdata <= mem[r_cur];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= '0;
        end else if (load) begin
            r_cur <= mod_tab[i_in.payload.resource];
        end else if (i_cmd.res_zero) begin
            r_cur <= '0;
        end else if (i_cmd.res_inc) begin
            r_cur <= (r_cur == R_LAST) ? '0 : r_cur + 1'b1;
        end else if (i_cmd.res_scan) begin
            r_cur <= r_pres[r_w];
        end else if (i_cmd.bfs_expand) begin
            r_cur <= r_pres[next_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tmo <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            r_tmo <= i_cfg_wdata;
        end
    end

    // waiter lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_cmd.enqueue) begin
                r_pend[r_tx]  <= 1'b1;
                r_pres[r_tx]  <= r_ires;
                r_pmode[r_tx] <= r_m;
                r_stamp[r_tx] <= r_cnt;
                r_age[r_tx]   <= '0;
                r_cnt         <= r_cnt + 32'd1;
            end
            if (i_cmd.pend_clr) begin
                r_pend[c_t] <= 1'b0;
            end
            if (i_cmd.age_inc) begin
                for (int w = 0; w < NUM_TXNS; w++) begin
                    if (r_pend[w] && (r_age[w] != 16'hFFFF)) begin
                        r_age[w] <= r_age[w] + 16'd1;
                    end
                end
            end
        end
    end

    // search registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.head_start) begin
            r_sc   <= TW'(1);
            r_best <= '0;
        end else if (i_cmd.head_step) begin
            if (head_take) begin
                r_best <= r_sc;
            end
            r_sc <= r_sc + 1'b1;
        end
        if (i_cmd.w_one) begin
            r_w <= TW'(1);
        end else if (i_cmd.w_inc) begin
            r_w <= r_w + 1'b1;
        end
        if (i_cmd.bfs_init) begin
            r_x        <= r_tx;
            r_reached  <= '0;
            r_expanded <= '0;
        end else begin
            if (i_cmd.bfs_eval) begin
                r_reached <= r_reached | blk;
            end
            if (i_cmd.bfs_expand) begin
                r_x        <= next_idx;
                r_expanded <= r_expanded | onehot(next_idx);
            end
        end
    end

    // held item moves out on a further event or at the end of the item
    assign out_load = (i_cmd.emit && r_hold_v) || i_cmd.flush;

    always_comb begin
        out_nx      = r_hold;
        out_nx.last = i_cmd.flush;
    end

    // event hold and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_hold_v <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_hold   <= ev;
                r_hold_v <= 1'b1;
            end else if (i_cmd.flush) begin
                r_hold_v <= 1'b0;
            end
            if (out_load) begin
                r_out   <= out_nx;
                r_out_v <= 1'b1;
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_out.valid   = r_out_v;
    assign o_out.payload = r_out;

    always_comb begin
        o_sts               = '0;
        o_sts.in_valid      = i_in.valid;
        o_sts.op            = r_op;
        o_sts.bad           = r_bad;
        o_sts.t_pend        = r_pend[r_tx];
        o_sts.sc_last       = (r_sc == T_LAST);
        o_sts.w_last        = (r_w == T_LAST);
        o_sts.res_last      = (r_cur == R_LAST);
        o_sts.holds         = holds;
        o_sts.compat        = compat;
        o_sts.best_zero     = (r_best == '0);
        o_sts.best_eq_w     = (r_best == r_w);
        o_sts.waiter_on_cur = |on_cur;
        o_sts.w_due         = r_pend[r_w] && (r_age[r_w] >= r_tmo);
        o_sts.reached_start = r_reached[r_tx];
        o_sts.next_found    = next_found;
        o_sts.emit_ok       = !r_hold_v || out_free;
        o_sts.hold_v        = r_hold_v;
        o_sts.out_free      = out_free;
    end

endmodule

// ===== rtl/core/selt_checker.sv =====
// port checker for the lock table and its bind
module selt_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input selt_pkg::t_out_item i_out_payload
);
    import selt_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_payload)))
        else $error("stalled event changed");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("event shown after reset");

    a_release_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_payload.event_res == EV_RELEASED))
            |-> (i_out_payload.event_resource == 6'd0))
        else $error("release event with resource");

    a_txn_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_payload.event_res != EV_INVALID))
            |-> (i_out_payload.event_txn != 4'd0))
        else $error("event for txn zero");

endmodule

bind shared_exclusive_lock_table_core selt_checker u_selt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_payload (o_out.payload)
);

// ===== tb/tb_if.sv =====
// testbench-side note: channel interfaces come from the rtl; this file holds shared tb types
package tb_lock_pkg;
    import selt_pkg::*;

    typedef struct {
        logic [1:0] operation;
        logic [3:0] txn;
        logic [5:0] resource;
        logic       mode;
        logic       has_expect;
        logic [2:0] exp_res;
        logic [3:0] exp_txn;
        logic [5:0] exp_resource;
    } t_stim_row;
endpackage

// ===== tb/testbench.sv =====
// testbench of the shared/exclusive lock table: directed table plus random traffic, predicted
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import selt_pkg::*;
    import tb_lock_pkg::*;

    localparam int NTX = 16;
    localparam int NRES = 64;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;

    selt_in_if  req_ch ();
    selt_out_if ev_ch ();

    shared_exclusive_lock_table_core #(.NUM_TXNS(NTX), .NUM_RESOURCES(NRES)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (req_ch.sink),
        .o_out       (ev_ch.source),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    // predictor state
    logic [15:0] lt_timeout;
    logic [3:0]  lt_xholder [NRES];
    logic [15:0] lt_sholders [NRES];
    logic        lt_pend [NTX];
    logic [5:0]  lt_pres [NTX];
    logic        lt_pmode [NTX];
    logic [31:0] lt_stamp [NTX];
    logic [15:0] lt_age [NTX];
    logic [31:0] lt_arrival;

    t_out_item  expected_events [$];
    int         errors = 0;
    int         idle_cycles = 0;
    int         accepted_items = 0;
    int         accepted_events = 0;
    logic       rx_hold = 1'b0;
    logic       stim_done = 1'b0;

    function automatic bit lt_earlier(int a, int b);
        return (lt_arrival - lt_stamp[a]) > (lt_arrival - lt_stamp[b]);
    endfunction

    function automatic int lt_head(int r);
        int best;
        best = 0;
        for (int w = 1; w < NTX; w++)
            if (lt_pend[w] && int'(lt_pres[w]) == r && (best == 0 || lt_earlier(w, best)))
                best = w;
        return best;
    endfunction

    function automatic bit lt_holds(int r, int t, bit m);
        if (lt_xholder[r] == 4'(t)) return 1'b1;
        return !m && lt_sholders[r][t];
    endfunction

    function automatic bit lt_compat(int r, int t, bit m);
        logic [15:0] others;
        if (lt_xholder[r] != 4'd0 && lt_xholder[r] != 4'(t)) return 1'b0;
        if (!m) return 1'b1;
        others = lt_sholders[r];
        others[t] = 1'b0;
        return others == 16'd0;
    endfunction

    function automatic void lt_grant(int r, int t, bit m);
        if (m) begin
            lt_xholder[r] = 4'(t);
            lt_sholders[r][t] = 1'b0;
        end else if (lt_xholder[r] != 4'(t)) begin
            lt_sholders[r][t] = 1'b1;
        end
        lt_pend[t] = 1'b0;
    endfunction

    function automatic logic [15:0] lt_blockers(int t);
        logic [15:0] mask;
        int r;
        r = int'(lt_pres[t]);
        mask = '0;
        if (lt_xholder[r] != 4'd0 && lt_xholder[r] != 4'(t)) mask[lt_xholder[r]] = 1'b1;
        if (lt_pmode[t]) begin
            mask |= lt_sholders[r];
            mask[t] = lt_sholders[r][t] ? 1'b0 : mask[t];
        end
        for (int w = 1; w < NTX; w++)
            if (w != t && lt_pend[w] && lt_pres[w] == 6'(r) && lt_earlier(w, t))
                mask[w] = 1'b1;
        return mask;
    endfunction

    function automatic bit lt_in_cycle(int start);
        logic [15:0] reached;
        logic [15:0] expanded;
        int nxt;
        reached = lt_blockers(start);
        expanded = '0;
        forever begin
            if (reached[start]) return 1'b1;
            nxt = 0;
            for (int w = 1; w < NTX; w++)
                if (reached[w] && !expanded[w] && lt_pend[w]) begin
                    nxt = w;
                    break;
                end
            if (nxt == 0) return 1'b0;
            expanded[nxt] = 1'b1;
            reached |= lt_blockers(nxt);
        end
    endfunction

    function automatic void lt_reset();
        lt_timeout = TIMEOUT_RESET;
        for (int r = 0; r < NRES; r++) begin
            lt_xholder[r] = '0;
            lt_sholders[r] = '0;
        end
        for (int t = 0; t < NTX; t++) begin
            lt_pend[t] = 1'b0;
            lt_pres[t] = '0;
            lt_pmode[t] = 1'b0;
            lt_stamp[t] = '0;
            lt_age[t] = '0;
        end
        lt_arrival = '0;
    endfunction

    // runs one request through the predictor, returns the events it causes
    function automatic void lt_predict(t_in_item it, ref t_out_item evs [$]);
        t_out_item e;
        int t, r, h, q;
        bit m, bad;
        t = int'(it.txn);
        r = int'(it.resource);
        m = it.mode;
        bad = (t == 0);
        evs = {};
        e = '0;
        if (it.operation == OP_ACQUIRE) begin
            if (bad || lt_pend[t]) begin
                e.event_res = EV_INVALID; e.event_txn = 4'(t); e.event_resource = 6'(r);
                evs.insert(evs.size(), e);
            end else if (lt_holds(r, t, m) || (lt_head(r) == 0 && lt_compat(r, t, m))) begin
                lt_grant(r, t, m);
                e.event_res = EV_GRANTED; e.event_txn = 4'(t); e.event_resource = 6'(r);
                evs.insert(evs.size(), e);
            end else begin
                lt_pend[t] = 1'b1;
                lt_pres[t] = 6'(r);
                lt_pmode[t] = m;
                lt_stamp[t] = lt_arrival;
                lt_age[t] = '0;
                lt_arrival++;
                if (lt_in_cycle(t)) begin
                    lt_pend[t] = 1'b0;
                    e.event_res = EV_DEADLOCK;
                end else begin
                    e.event_res = EV_WAITING;
                end
                e.event_txn = 4'(t); e.event_resource = 6'(r);
                evs.insert(evs.size(), e);
            end
        end else if (it.operation == OP_RELEASE) begin
            if (bad) begin
                e.event_res = EV_INVALID; e.event_txn = 4'(t); e.event_resource = '0;
                evs.insert(evs.size(), e);
            end else begin
                for (q = 0; q < NRES; q++) begin
                    if (lt_xholder[q] == 4'(t)) lt_xholder[q] = '0;
                    lt_sholders[q][t] = 1'b0;
                end
                lt_pend[t] = 1'b0;
                e.event_res = EV_RELEASED; e.event_txn = 4'(t); e.event_resource = '0;
                evs.insert(evs.size(), e);
                for (q = 0; q < NRES; q++) begin
                    forever begin
                        h = lt_head(q);
                        if (h == 0) break;
                        if (!lt_holds(q, h, lt_pmode[h]) && !lt_compat(q, h, lt_pmode[h]))
                            break;
                        lt_grant(q, h, lt_pmode[h]);
                        e.event_res = EV_GRANTED_WAIT;
                        e.event_txn = 4'(h);
                        e.event_resource = 6'(q);
                        evs.insert(evs.size(), e);
                    end
                end
            end
        end else if (it.operation == OP_TICK) begin
            for (int w = 1; w < NTX; w++)
                if (lt_pend[w] && lt_age[w] != 16'hFFFF) lt_age[w]++;
            for (int w = 1; w < NTX; w++) begin
                if (!lt_pend[w] || lt_age[w] < lt_timeout) continue;
                q = int'(lt_pres[w]);
                if (lt_holds(q, w, lt_pmode[w]) ||
                    (lt_head(q) == w && lt_compat(q, w, lt_pmode[w]))) begin
                    lt_grant(q, w, lt_pmode[w]);
                    e.event_res = EV_GRANTED_WAIT;
                end else begin
                    lt_pend[w] = 1'b0;
                    e.event_res = EV_TIMEOUT;
                end
                e.event_txn = 4'(w); e.event_resource = 6'(q);
                evs.insert(evs.size(), e);
            end
        end
        if (evs.size() > 0) evs[evs.size() - 1].last = 1'b1;
    endfunction

    task automatic send_request(t_in_item it, bit has_exp, t_out_item exp_ev);
        t_out_item evs [$];
        int gap;
        gap = $urandom_range(0, 3);
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.payload <= it;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        accepted_items++;
        lt_predict(it, evs);
        if (has_exp && (evs.size() != 1 || evs[0] != exp_ev)) begin
            $display("%0t: directed row mismatch, expected %p, predicted %p",
                     $time, exp_ev, evs);
            errors++;
        end
        foreach (evs[k]) expected_events.insert(expected_events.size(), evs[k]);
        @(negedge i_clk);
    endtask

    task automatic write_timeout(logic [15:0] val);
        req_ch.valid <= 1'b0;
        while (expected_events.size() != 0) @(negedge i_clk);
        repeat (250) @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        lt_timeout = val;
    endtask

    function automatic t_in_item mk(logic [1:0] op, int t, int r, bit m);
        t_in_item it;
        it.operation = op; it.txn = 4'(t); it.resource = 6'(r); it.mode = m;
        return it;
    endfunction

    function automatic t_out_item ev(logic [2:0] c, int t, int r);
        t_out_item e;
        e.event_res = c; e.event_txn = 4'(t); e.event_resource = 6'(r); e.last = 1'b1;
        return e;
    endfunction

    // event side: random wait per item, one long hold-off
    initial begin
        int gap;
        ev_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            gap = $urandom_range(0, 3);
            repeat (gap) begin
                @(negedge i_clk);
                ev_ch.ready <= 1'b0;
            end
            do begin
                @(negedge i_clk);
                ev_ch.ready <= !rx_hold;
                @(posedge i_clk);
            end while (!(ev_ch.valid && ev_ch.ready));
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && ev_ch.valid && ev_ch.ready) begin
            accepted_events++;
            if (expected_events.size() == 0) begin
                $display("%0t: unexpected event, actual %p", $time, ev_ch.payload);
                errors++;
            end else begin
                t_out_item e;
                e = expected_events.pop_front();
                if (ev_ch.payload.event_res !== e.event_res ||
                    ev_ch.payload.event_txn !== e.event_txn ||
                    ev_ch.payload.event_resource !== e.event_resource ||
                    ev_ch.payload.last !== e.last)
                    begin
                    $display("%0t: event mismatch, expected %p, actual %p",
                             $time, e, ev_ch.payload);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (ev_ch.valid && ev_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    t_stim_row dir_table [18] = '{
        '{OP_ACQUIRE, 4'd0,  6'd5,  1'b0, 1'b1, EV_INVALID, 4'd0,  6'd5},
        '{OP_RELEASE, 4'd0,  6'd0,  1'b0, 1'b1, EV_INVALID, 4'd0,  6'd0},
        '{OP_ACQUIRE, 4'd1,  6'd0,  1'b0, 1'b1, EV_GRANTED, 4'd1,  6'd0},
        '{OP_ACQUIRE, 4'd2,  6'd0,  1'b0, 1'b1, EV_GRANTED, 4'd2,  6'd0},
        '{OP_ACQUIRE, 4'd15, 6'd63, 1'b1, 1'b1, EV_GRANTED, 4'd15, 6'd63},
        '{OP_ACQUIRE, 4'd3,  6'd63, 1'b0, 1'b1, EV_WAITING, 4'd3,  6'd63},
        '{OP_ACQUIRE, 4'd3,  6'd1,  1'b0, 1'b1, EV_INVALID, 4'd3,  6'd1},
        '{OP_ACQUIRE, 4'd1,  6'd0,  1'b1, 1'b0, EV_GRANTED, 4'd0,  6'd0},
        '{OP_ACQUIRE, 4'd15, 6'd0,  1'b0, 1'b0, EV_GRANTED, 4'd0,  6'd0},
        '{OP_ACQUIRE, 4'd2,  6'd63, 1'b1, 1'b0, EV_GRANTED, 4'd0,  6'd0},
        '{OP_ACQUIRE, 4'd15, 6'd10, 1'b1, 1'b0, EV_GRANTED, 4'd0,  6'd0},
        '{OP_TICK,    4'd0,  6'd0,  1'b0, 1'b0, EV_GRANTED, 4'd0,  6'd0},
        '{OP_TICK,    4'd0,  6'd0,  1'b0, 1'b0, EV_GRANTED, 4'd0,  6'd0},
        '{OP_RELEASE, 4'd15, 6'd0,  1'b0, 1'b0, EV_GRANTED, 4'd0,  6'd0},
        '{OP_RELEASE, 4'd1,  6'd0,  1'b0, 1'b0, EV_GRANTED, 4'd0,  6'd0},
        '{OP_RELEASE, 4'd2,  6'd0,  1'b0, 1'b0, EV_GRANTED, 4'd0,  6'd0},
        '{OP_RELEASE, 4'd3,  6'd0,  1'b0, 1'b0, EV_GRANTED, 4'd0,  6'd0},
        '{OP_NOP,     4'd7,  6'd42, 1'b1, 1'b0, EV_GRANTED, 4'd0,  6'd0}
    };

    initial begin
        t_in_item it;
        int phase_items;
        int pick;
        bit held;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        lt_reset();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_table[k]) begin
            it = mk(dir_table[k].operation, int'(dir_table[k].txn),
                    int'(dir_table[k].resource), dir_table[k].mode);
            send_request(it, dir_table[k].has_expect,
                         ev(dir_table[k].exp_res, int'(dir_table[k].exp_txn),
                            int'(dir_table[k].exp_resource)));
        end

        // phases through several timeouts, extremes included
        held = 1'b0;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_timeout(16'd1);
                1: write_timeout(16'd3);
                2: write_timeout(16'hFFFF);
                default: write_timeout(16'd2);
            endcase
            phase_items = 22;
            for (int n = 0; n < phase_items; n++) begin
                if (ph == 1 && n == 5 && !held) begin
                    held = 1'b1;
                    fork
                        begin
                            rx_hold = 1'b1;
                            repeat (400) @(negedge i_clk);
                            rx_hold = 1'b0;
                        end
                    join_none
                end
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    it = mk(OP_ACQUIRE, $urandom_range(1, 6), $urandom_range(0, 3),
                            1'($urandom_range(0, 1)));
                else if (pick < 8)
                    it = mk(OP_RELEASE, $urandom_range(1, 6), $urandom, 1'($urandom));
                else if (pick < 9)
                    it = mk(OP_TICK, $urandom, $urandom, 1'($urandom));
                else
                    it = mk(2'($urandom_range(0, 1)), $urandom, $urandom, 1'($urandom));
                send_request(it, 1'b0, '0);
            end
            for (int t = 1; t < NTX; t++)
                send_request(mk(OP_RELEASE, t, 0, 1'b0), 1'b0, '0);
        end

        req_ch.valid <= 1'b0;
        while (expected_events.size() != 0 || rx_hold) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        if (errors == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
